/* sv/sorted_priority_queue_core_macros.svh */
// Assertion macros for the sorted priority queue core.
// Used by sorted_priority_queue_core.sv; expects clk_i and rst_ni in scope.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/spq_pkg.sv */
// Shared types, codes and helpers for the sorted priority queue core.
// No dependencies; used by spq_ctrl, spq_dp and sorted_priority_queue_core.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned PADDR_W      = 3;

  // item commands
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // register index (paddr[2])
  localparam logic REG_ORDER_MODE = 1'b0;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_EMPTY,
    RES_FULL,
    RES_HEAD
  } res_kind_e;

  typedef struct packed {
    logic      load;
    logic      rd_head;
    logic      rd_pos;
    logic      push_step;
    logic      push_tail;
    logic      pop_adv;
    logic      emit;
    res_kind_e res;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic at_tail;
  } dp_stat_t;

  // stored priority x goes ahead of (or ties with) new priority p
  function automatic logic stands_before(input logic order_mode,
                                         input logic signed [DATA_W-1:0] x,
                                         input logic signed [DATA_W-1:0] p);
    logic r;
    if (order_mode) begin
      r = (x >= p);
    end else begin
      r = (x <= p);
    end
    return r;
  endfunction

endpackage

/* sv/spq_ctrl.sv */
// Sequencer of the sorted priority queue: accepts items and drives the datapath.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd_i,
  input  spq_pkg::dp_stat_t   stat_i,
  output spq_pkg::dp_cmd_t    dp_cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRD  = 2'd1;
  localparam logic [1:0] S_PCMP = 2'd2;
  localparam logic [1:0] S_HOUT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       is_pop_q, is_pop_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    is_pop_d = is_pop_q;
    dp_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            spq_pkg::CMD_PUSH: begin
              if (stat_i.full) begin
                dp_cmd_o.emit = 1'b1;
                dp_cmd_o.res  = spq_pkg::RES_FULL;
              end else begin
                dp_cmd_o.load = 1'b1;
                state_d       = S_PRD;
              end
            end
            spq_pkg::CMD_POP, spq_pkg::CMD_PEEK: begin
              if (stat_i.empty) begin
                dp_cmd_o.emit = 1'b1;
                dp_cmd_o.res  = spq_pkg::RES_EMPTY;
              end else begin
                dp_cmd_o.rd_head = 1'b1;
                is_pop_d         = (cmd_i == spq_pkg::CMD_POP);
                state_d          = S_HOUT;
              end
            end
            default: begin
              dp_cmd_o.emit = 1'b1;
              dp_cmd_o.res  = spq_pkg::RES_NONE;
            end
          endcase
        end
      end
      S_PRD: begin
        if (stat_i.at_tail) begin
          dp_cmd_o.push_tail = 1'b1;
          dp_cmd_o.emit      = 1'b1;
          dp_cmd_o.res       = spq_pkg::RES_NONE;
          state_d            = S_IDLE;
        end else begin
          dp_cmd_o.rd_pos = 1'b1;
          state_d         = S_PCMP;
        end
      end
      S_PCMP: begin
        dp_cmd_o.push_step = 1'b1;
        state_d            = S_PRD;
      end
      S_HOUT: begin
        dp_cmd_o.emit    = 1'b1;
        dp_cmd_o.res     = spq_pkg::RES_HEAD;
        dp_cmd_o.pop_adv = is_pop_q;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      is_pop_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_pop_q <= is_pop_d;
    end
  end

endmodule

/* sv/spq_dp.sv */
// Datapath of the sorted priority queue: circular entry memory, insertion walk
// and result registers. Depends on spq_pkg.
module spq_dp #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spq_pkg::dp_cmd_t                    cmd_i,
  input  logic                                order_mode_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_priority_i,
  output spq_pkg::dp_stat_t                   stat_o,
  output logic                                done_o,
  output logic signed [spq_pkg::DATA_W-1:0]   head_value_o,
  output logic signed [spq_pkg::DATA_W-1:0]   head_priority_o,
  output logic [1:0]                          status_o,
  output logic                                now_empty_o
);

  localparam int unsigned DW   = spq_pkg::DATA_W;
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW:0]   CapX    = (CntW + 1)'(CAPACITY);
  localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  // logical position -> memory slot, head-relative
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] lpos);
    logic [CntW:0] sum;
    sum = (CntW + 1)'(head) + {1'b0, lpos};
    if (sum >= CapX) begin
      sum = sum - CapX;
    end
    return sum[IdxW-1:0];
  endfunction

  logic [2*DW-1:0] mem_q [CAPACITY];
  logic [2*DW-1:0] rd_q;

  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            inserted_q, inserted_d;
  logic [DW-1:0]   carry_val_q, carry_pri_q;
  logic            done_q;
  logic [DW-1:0]   hv_q, hp_q;
  logic [1:0]      status_q;
  logic            now_empty_q;

  logic [DW-1:0]   rd_val, rd_pri;
  logic [IdxW-1:0] pos_addr, raddr;
  logic            re, we, keep;

  assign rd_val   = rd_q[2*DW-1:DW];
  assign rd_pri   = rd_q[DW-1:0];
  assign pos_addr = phys(head_q, pos_q);
  assign raddr    = cmd_i.rd_head ? head_q : pos_addr;
  assign re       = cmd_i.rd_head | cmd_i.rd_pos;
  // still in front of the insertion point: entry stays where it is
  assign keep     = !inserted_q && spq_pkg::stands_before(order_mode_i, rd_pri, carry_pri_q);
  assign we       = cmd_i.push_tail | (cmd_i.push_step & !keep);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[pos_addr] <= {carry_val_q, carry_pri_q};
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    pos_d      = pos_q;
    inserted_d = inserted_q;
    if (cmd_i.load) begin
      pos_d      = '0;
      inserted_d = 1'b0;
    end
    if (cmd_i.push_step) begin
      pos_d = pos_q + 1'b1;
      if (!keep) begin
        inserted_d = 1'b1;
      end
    end
    if (cmd_i.push_tail) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop_adv) begin
      count_d = count_q - 1'b1;
      head_d  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      pos_q      <= '0;
      inserted_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      head_q     <= head_d;
      count_q    <= count_d;
      pos_q      <= pos_d;
      inserted_q <= inserted_d;
      done_q     <= cmd_i.emit;
    end
  end

  // carried entry: new item first, then each displaced entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      carry_val_q <= item_value_i;
      carry_pri_q <= item_priority_i;
    end else if (cmd_i.push_step && !keep) begin
      carry_val_q <= rd_val;
      carry_pri_q <= rd_pri;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      now_empty_q <= (count_d == '0);
      case (cmd_i.res)
        spq_pkg::RES_HEAD: begin
          hv_q     <= rd_val;
          hp_q     <= rd_pri;
          status_q <= spq_pkg::STATUS_OK;
        end
        spq_pkg::RES_EMPTY: begin
          hv_q     <= '0;
          hp_q     <= '0;
          status_q <= spq_pkg::STATUS_EMPTY;
        end
        spq_pkg::RES_FULL: begin
          hv_q     <= '0;
          hp_q     <= '0;
          status_q <= spq_pkg::STATUS_FULL;
        end
        default: begin
          hv_q     <= '0;
          hp_q     <= '0;
          status_q <= spq_pkg::STATUS_OK;
        end
      endcase
    end
  end

  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q == CapCnt);
  assign stat_o.at_tail = (pos_q == count_q);

  assign done_o          = done_q;
  assign head_value_o    = hv_q;
  assign head_priority_o = hp_q;
  assign status_o        = status_q;
  assign now_empty_o     = now_empty_q;

endmodule

/* sv/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue core: APB config register, sequencer
// and datapath. Depends on spq_pkg, spq_ctrl, spq_dp and the core macros header.
//
//   channel   handshake                    payload
//   item in   start & !busy                cmd_i, item_value_i, item_priority_i
//   result    done_o (one cycle, no stall) head_value_o, head_priority_o,
//                                          status_o, now_empty_o
//   config    psel & penable & pwrite      paddr (reg 0 = order_mode), pwdata
//
// Cycles: refused push, pop/peek on empty and the unused command raise done_o the
// cycle after acceptance, busy stays low. Pop/peek: busy during the head readout, done_o as busy drops.
// A push onto N entries walks the single-port memory (read, then compare/write per
// entry) while busy; done_o rises in the same cycle that busy drops.
// Reset clears count, head pointer and order_mode; entry memory is left as is.
// done_o cannot be stalled; a new item may be accepted while it is up.
module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_priority_i,
  // result channel
  output logic                                done_o,
  output logic signed [spq_pkg::DATA_W-1:0]   head_value_o,
  output logic signed [spq_pkg::DATA_W-1:0]   head_priority_o,
  output logic [1:0]                          status_o,
  output logic                                now_empty_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [spq_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  spq_pkg::dp_cmd_t  dp_cmd;
  spq_pkg::dp_stat_t dp_stat;

  logic order_mode_q, order_mode_d;
  logic reg_hit;

  // shorthand terms for the checks at the end
  logic push_room, res_full, res_empty, head_zero;

  // word index sits in paddr[2]; anything past order_mode is ignored
  assign reg_hit = (paddr[2] == spq_pkg::REG_ORDER_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {31'b0, order_mode_q} : 32'b0;

  always_comb begin
    order_mode_d = order_mode_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      order_mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b0;
    end else begin
      order_mode_q <= order_mode_d;
    end
  end

  spq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .stat_i   (dp_stat),
    .dp_cmd_o (dp_cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .order_mode_i    (order_mode_q),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .stat_o          (dp_stat),
    .done_o          (done_o),
    .head_value_o    (head_value_o),
    .head_priority_o (head_priority_o),
    .status_o        (status_o),
    .now_empty_o     (now_empty_o)
  );

  assign push_room = start && !busy && (cmd_i == spq_pkg::CMD_PUSH) && !dp_stat.full;
  assign res_full  = done_o && (status_o == spq_pkg::STATUS_FULL);
  assign res_empty = done_o && (status_o == spq_pkg::STATUS_EMPTY);
  assign head_zero = (head_value_o == '0) && (head_priority_o == '0);

`include "sorted_priority_queue_core_macros.svh"

  // a result only ever follows an accepted or in-flight item
  `SPQ_ASSERT_IMP(a_done_has_source, done_o, $past(start || busy), "result without item")
  // a refused push means the store was full, never empty
  `SPQ_ASSERT_IMP(a_full_not_empty, res_full, !now_empty_o, "full status, empty queue")
  // empty pop/peek reports zeros and an empty queue
  `SPQ_ASSERT_IMP(a_empty_zeros, res_empty, now_empty_o && head_zero, "empty status, data")
  // an accepted push with room starts the insertion walk
  `SPQ_ASSERT_NXT(a_push_walks, push_room, busy, "push did not start walk")

endmodule

/* sim/tb_sorted_priority_queue_core.sv */
// Self-checking testbench for sorted_priority_queue_core: directed and random push/pop/peek
// items with a shadow sorted queue predicting every head report. Needs spq_pkg and the RTL.
module tb_sorted_priority_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned DEPTH       = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // worst push walks all entries, plus its result
  localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;

  localparam logic [1:0]         CMD_UNUSED      = 2'd3;
  localparam logic [PADDR_W-1:0] ORDER_MODE_ADDR = 3'd0;
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR   = 3'd4;   // register index 1, not mapped

  // one item waiting for the driver
  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic                     wait_drain;   // hold back until every result is in
  } queue_cmd_t;

  // one result as the block reports it
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic [1:0]               status;
    logic                     now_empty;
  } head_report_t;

  // DUT signals: every input known from time zero
  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     start           = 1'b0;
  logic                     busy;
  logic [1:0]               cmd_i           = CMD_PUSH;
  logic signed [DATA_W-1:0] item_value_i    = '0;
  logic signed [DATA_W-1:0] item_priority_i = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] head_value_o;
  logic signed [DATA_W-1:0] head_priority_o;
  logic [1:0]               status_o;
  logic                     now_empty_o;
  logic                     psel            = 1'b0;
  logic                     penable         = 1'b0;
  logic                     pwrite          = 1'b0;
  logic [PADDR_W-1:0]       paddr           = '0;
  logic [31:0]              pwdata          = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // testbench state
  queue_cmd_t   cmd_backlog[$];      // items not yet presented
  head_report_t reports_due[$];      // predicted results, oldest first
  int unsigned  gap_left       = 0;
  bit           idle_off       = 1'b0;  // no sender gaps in the closing stretch
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;

  // shadow of the sorted store; head at index 0
  logic signed [DATA_W-1:0] held_value[DEPTH];
  logic signed [DATA_W-1:0] held_prio[DEPTH];
  int unsigned              held_count    = 0;
  logic                     largest_first = 1'b0;   // order_mode

  sorted_priority_queue_core #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .done_o         (done_o),
    .head_value_o   (head_value_o),
    .head_priority_o(head_priority_o),
    .status_o       (status_o),
    .now_empty_o    (now_empty_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Run guard: a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               reports_due.size());
      $display("** sorted_priority_queue_core: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Apply one item to the shadow store and return the report it should give.
  // A push goes behind every held entry that leaves before or ties with it,
  // so equal priorities keep arrival order.
  function automatic head_report_t apply_to_shadow_queue(input logic [1:0] cmd,
                                                         input logic signed [DATA_W-1:0] val,
                                                         input logic signed [DATA_W-1:0] prio);
    head_report_t rep;
    int unsigned  slot;
    int unsigned  k;
    rep = '0;
    case (cmd)
      CMD_PUSH: begin
        if (held_count == DEPTH) begin
          rep.status = STATUS_FULL;
        end else begin
          slot = 0;
          while (slot < held_count &&
                 (largest_first ? held_prio[slot] >= prio : held_prio[slot] <= prio))
            slot++;
          for (k = held_count; k > slot; k--) begin
            held_value[k] = held_value[k-1];
            held_prio[k]  = held_prio[k-1];
          end
          held_value[slot] = val;
          held_prio[slot]  = prio;
          held_count++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (held_count == 0) begin
          rep.status = STATUS_EMPTY;
        end else begin
          rep.value = held_value[0];
          rep.prio  = held_prio[0];
          if (cmd == CMD_POP) begin
            for (k = 1; k < held_count; k++) begin
              held_value[k-1] = held_value[k];
              held_prio[k-1]  = held_prio[k];
            end
            held_count--;
          end
        end
      end
      default: begin
        // unused command: no change, plain ok report
      end
    endcase
    rep.now_empty = (held_count == 0);
    return rep;
  endfunction

  // Driver: presents backlog items on start, holds them while busy, and
  // inserts random gaps after some accepted items.
  always @(posedge clk_i) begin : drive_items
    logic        fire;
    int unsigned gap;
    queue_cmd_t  nxt;
    fire = start && !busy;
    gap  = gap_left;
    if (fire && !idle_off && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 5);
    if (!rst_ni || (start && !fire)) begin
      // in reset, or item still waiting for acceptance
    end else if (gap > 0) begin
      start    <= 1'b0;
      gap_left <= gap - 1;
    end else if (cmd_backlog.size() != 0 &&
                 (!cmd_backlog[0].wait_drain ||
                  (!fire && !done_o && reports_due.size() == 0))) begin
      // a drain item goes out only once nothing is in flight and the queue is
      // stable at this edge (no acceptance, no result being taken)
      nxt             = cmd_backlog.pop_front();
      start           <= 1'b1;
      cmd_i           <= nxt.cmd;
      item_value_i    <= nxt.value;
      item_priority_i <= nxt.prio;
      gap_left        <= 0;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks a result before predicting the item accepted at the same
  // edge, so a stray strobe is never matched against a fresh prediction.
  always @(posedge clk_i) begin : watch_results
    head_report_t got;
    head_report_t want;
    if (rst_ni) begin
      if (done_o) begin
        got = '{head_value_o, head_priority_o, status_o, now_empty_o};
        if (reports_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = reports_due.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("head_value %0d, want %0d", got.value, want.value));
          if (got.prio !== want.prio)
            report_mismatch($sformatf("head_priority %0d, want %0d", got.prio, want.prio));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.now_empty !== want.now_empty)
            report_mismatch($sformatf("now_empty %b, want %b", got.now_empty,
                                      want.now_empty));
        end
      end
      if (start && !busy)
        reports_due.push_back(apply_to_shadow_queue(cmd_i, item_value_i, item_priority_i));
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [DATA_W-1:0] val,
                            input logic [DATA_W-1:0] prio, input logic wait_drain = 1'b0);
    cmd_backlog.push_back('{cmd, val, prio, wait_drain});
  endtask

  // Wait until the backlog is out and every result is in, plus some slack.
  task automatic wait_quiet(input int unsigned extra);
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || reports_due.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  // APB write: setup then access; the register takes it at the closing edge.
  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ORDER_MODE_ADDR)
      largest_first = data[0];
  endtask

  // order_mode write with junk in the unused upper bits
  task automatic set_order(input logic mode);
    write_register(ORDER_MODE_ADDR, ($urandom() & 32'hFFFF_FFFE) | mode);
  endtask

  // Random items in runs of 24 with a push bias of 15, 50 or 85 percent, so
  // the store swings between empty and full. Priorities mix narrow ranges
  // (many ties), the extremes and full-range values.
  task automatic queue_random_items(input int unsigned count, input int unsigned drain_at);
    queue_cmd_t  it;
    int unsigned push_pct;
    int unsigned n;
    push_pct = 50;
    for (n = 0; n < count; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      it.value = $urandom();
      case ($urandom_range(0, 3))
        0: it.prio = $urandom_range(0, 7);
        1: it.prio = $urandom_range(0, 15) - 8;
        2: begin
          case ($urandom_range(0, 3))
            0:       it.prio = 32'h8000_0000;
            1:       it.prio = 32'h7FFF_FFFF;
            2:       it.prio = '0;
            default: it.prio = '1;
          endcase
        end
        default: it.prio = $urandom();
      endcase
      if ($urandom_range(0, 99) < push_pct) begin
        it.cmd = CMD_PUSH;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:2]:   it.cmd = CMD_UNUSED;
          [3:27]:  it.cmd = CMD_PEEK;
          default: it.cmd = CMD_POP;
        endcase
      end
      it.wait_drain = (n == drain_at);
      cmd_backlog.push_back(it);
    end
  endtask

  initial begin : run_test
    int unsigned i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, smaller priority first (reset order).
    // Empty store: pop, peek and the unused command.
    queue_item(CMD_POP,    32'h1234_5678, 32'h1);
    queue_item(CMD_PEEK,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    // extremes of value and priority
    queue_item(CMD_PUSH,   32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(CMD_PUSH,   32'h8000_0000, 32'h7FFF_FFFF);
    // three equal priorities: must leave in arrival order
    queue_item(CMD_PUSH,   32'h0,         32'h0);
    queue_item(CMD_PUSH,   32'h1,         32'h0);
    queue_item(CMD_PUSH,   32'h2,         32'h0);
    queue_item(CMD_PEEK,   32'h0,         32'h0);
    queue_item(CMD_PUSH,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill to capacity, then a refused push and more at full
    for (i = 0; i < DEPTH - 6; i++)
      queue_item(CMD_PUSH, $urandom(), $urandom_range(0, 7) - 4);
    queue_item(CMD_PUSH,   32'hDEAD_BEEF, 32'h0);
    queue_item(CMD_UNUSED, 32'h0,         32'h0);
    queue_item(CMD_PEEK,   32'h0,         32'h0);
    queue_item(CMD_POP,    32'h0,         32'h0);
    queue_item(CMD_POP,    32'h0,         32'h0);
    queue_item(CMD_POP,    32'h0,         32'h0);
    wait_quiet(2);

    // Flip to larger-first while 13 entries are held: stored order is kept,
    // new pushes follow the new rule. Also poke the unmapped register index.
    set_order(1'b1);
    write_register(UNMAPPED_ADDR, $urandom());
    queue_random_items(180, 90);
    wait_quiet(2);

    set_order(1'b0);
    queue_random_items(180, 200);
    wait_quiet(2);

    write_register(UNMAPPED_ADDR, $urandom());
    set_order(1'b1);
    queue_random_items(180, 40);
    wait_quiet(2);

    set_order(1'b1);   // same value again
    queue_random_items(180, 200);
    wait_quiet(2);

    set_order(1'b0);
    queue_random_items(180, 120);
    wait_quiet(2);

    // closing stretch: back-to-back items, no sender gaps
    set_order(1'b1);
    idle_off = 1'b1;
    queue_random_items(180, 200);

    wait_quiet(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("** sorted_priority_queue_core: PASSED **");
    end else begin
      $display("** sorted_priority_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
